@@ hdl/pil_pkg.sv @@
// Shared types and constants of the positional insert list.
package pil_pkg;

	// Default capacity of the element store
	localparam int PIL_DEPTH = 64;
	// Most results a single dump produces
	localparam int MAX_OUT = 64;

	// Command codes
	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_DUMP   = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]          command;
		logic signed [31:0]  value;
		logic [7:0]          position;
	} pil_req_t;

	typedef struct packed {
		logic signed [31:0]  data;
		logic [5:0]          slot;
		logic [6:0]          count;
		logic [1:0]          status;
		logic                last;
	} pil_res_t;

	// Which result the datapath registers this cycle
	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_FULL,
		EMIT_EMPTY,
		EMIT_WRITE,
		EMIT_DUMP
	} pil_emit_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic      load_ins;
		logic      load_dump;
		logic      rd_shift;
		logic      wr_shift;
		logic      rd_dump;
		logic      wr_value;
		pil_emit_t emit;
	} pil_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic tail;
		logic shift_last;
		logic dump_last;
	} pil_stat_t;

endpackage

@@ hdl/pil_ctrl.sv @@
// Controller state machine of the positional insert list.
module pil_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         command,
	input  pil_pkg::pil_stat_t stat,
	output pil_pkg::pil_cmd_t  cmd,
	output logic               busy
);
	import pil_pkg::*;

	typedef enum logic [5:0] {
		IDLE     = 6'b000001,
		SH_RD    = 6'b000010,
		SH_WR    = 6'b000100,
		WRITE    = 6'b001000,
		DUMP_RD  = 6'b010000,
		DUMP_OUT = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = (state_q != IDLE);

	// Decode the next state and the datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.emit = EMIT_NONE;
		unique case (state_q)
			IDLE: begin
				if (start) begin
					unique case (command)
						CMD_APPEND, CMD_INSERT: begin
							if (stat.full) begin
								cmd.emit = EMIT_FULL;
							end else begin
								cmd.load_ins = 1'b1;
								state_d = stat.tail ? WRITE : SH_RD;
							end
						end
						CMD_DUMP: begin
							if (stat.empty) begin
								cmd.emit = EMIT_EMPTY;
							end else begin
								cmd.load_dump = 1'b1;
								state_d = DUMP_RD;
							end
						end
						default: begin
							state_d = IDLE;
						end
					endcase
				end
			end
			SH_RD: begin
				cmd.rd_shift = 1'b1;
				state_d = SH_WR;
			end
			SH_WR: begin
				cmd.wr_shift = 1'b1;
				state_d = stat.shift_last ? WRITE : SH_RD;
			end
			WRITE: begin
				cmd.wr_value = 1'b1;
				cmd.emit = EMIT_WRITE;
				state_d = IDLE;
			end
			DUMP_RD: begin
				cmd.rd_dump = 1'b1;
				state_d = DUMP_OUT;
			end
			DUMP_OUT: begin
				cmd.emit = EMIT_DUMP;
				state_d = stat.dump_last ? IDLE : DUMP_RD;
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hdl/pil_dp.sv @@
// Datapath of the positional insert list: store, count, index and result register.
module pil_dp #(
	parameter int DEPTH = pil_pkg::PIL_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pil_pkg::pil_req_t  request,
	input  pil_pkg::pil_cmd_t  cmd,
	output pil_pkg::pil_stat_t stat,
	output logic               strobe,
	output pil_pkg::pil_res_t  result
);
	import pil_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 8) ? CW : 8;
	localparam int LW = (CW > 7) ? CW : 7;

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rd_q;
	logic signed [31:0] value_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      pos_q;
	logic [LW-1:0]      lim_q;
	logic               strobe_q;
	pil_res_t           res_q;

	logic [PW-1:0] pos_ext;
	logic [PW-1:0] cnt_ext;
	logic [PW-1:0] clamped;
	logic [CW-1:0] tgt;
	logic [LW-1:0] cnt_l;
	logic [LW-1:0] lim_d;
	logic [AW-1:0] addr;
	logic [CW-1:0] count_inc;

	// Clamp the insert position to the count; append goes to the tail
	assign pos_ext = PW'(request.position);
	assign cnt_ext = PW'(count_q);
	assign clamped = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
	assign tgt     = (request.command == CMD_APPEND) ? count_q : CW'(clamped);

	// Limit a dump to the most results one request may give
	assign cnt_l = LW'(count_q);
	assign lim_d = (cnt_l > LW'(MAX_OUT)) ? LW'(MAX_OUT) : cnt_l;

	assign count_inc = count_q + CW'(1);

	assign stat.full       = (count_q >= CW'(DEPTH));
	assign stat.empty      = (count_q == '0);
	assign stat.tail       = (tgt == count_q);
	assign stat.shift_last = (idx_q == pos_q + AW'(1));
	assign stat.dump_last  = ((LW'(idx_q) + LW'(1)) == lim_q);

	// Pick the single memory address for this cycle
	always_comb begin
		priority if (cmd.rd_shift) begin
			addr = idx_q - AW'(1);
		end else if (cmd.wr_value) begin
			addr = pos_q;
		end else begin
			addr = idx_q;
		end
	end

	// Single-port store, read data registered
	always_ff @(posedge clk) begin
		if (cmd.wr_shift) begin
			mem[addr] <= rd_q;
		end else if (cmd.wr_value) begin
			mem[addr] <= value_q;
		end
		if (cmd.rd_shift || cmd.rd_dump) begin
			rd_q <= mem[addr];
		end
	end

	// Hold the request operands
	always_ff @(posedge clk) begin
		if (cmd.load_ins) begin
			value_q <= request.value;
			pos_q   <= tgt[AW-1:0];
		end
		if (cmd.load_dump) begin
			lim_q <= lim_d;
		end
	end

	// Track element count and walking index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.wr_value) begin
				count_q <= count_inc;
			end
			priority if (cmd.load_ins) begin
				idx_q <= count_q[AW-1:0];
			end else if (cmd.load_dump) begin
				idx_q <= '0;
			end else if (cmd.wr_shift) begin
				idx_q <= idx_q - AW'(1);
			end else if (cmd.emit == EMIT_DUMP) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	// Register the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.emit != EMIT_NONE);
		end
	end

	// Register the result payload
	always_ff @(posedge clk) begin
		unique case (cmd.emit)
			EMIT_FULL: begin
				res_q.data   <= request.value;
				res_q.slot   <= '0;
				res_q.count  <= 7'(count_q);
				res_q.status <= ST_FULL;
				res_q.last   <= 1'b1;
			end
			EMIT_EMPTY: begin
				res_q.data   <= '0;
				res_q.slot   <= '0;
				res_q.count  <= '0;
				res_q.status <= ST_EMPTY;
				res_q.last   <= 1'b1;
			end
			EMIT_WRITE: begin
				res_q.data   <= value_q;
				res_q.slot   <= 6'(pos_q);
				res_q.count  <= 7'(count_inc);
				res_q.status <= ST_OK;
				res_q.last   <= 1'b1;
			end
			EMIT_DUMP: begin
				res_q.data   <= rd_q;
				res_q.slot   <= 6'(idx_q);
				res_q.count  <= 7'(count_q);
				res_q.status <= ST_OK;
				res_q.last   <= stat.dump_last;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule

@@ hdl/positional_insert_list_top.sv @@
// Top level of the positional insert list: controller plus datapath.
//
//  channel   direction  handshake                  payload
//  request   in         start high, busy low       pil_req_t  (command, value, position)
//  result    out        strobe high for one cycle  pil_res_t  (data, slot, count, status, last)
//
// Append writes the value straight from idle. Insert first moves up the k entries
// at and above its position, each move a read then a write of the one single-port
// store, then writes the value. A dump reads and then emits each element in turn.
// Refused writes, empty dumps and unused commands are settled in idle. Results are
// registered, so each appears in the cycle after it is formed; the receiver cannot
// stall them. Reset clears the count; the store has no reset and needs no clearing.
module positional_insert_list_top #(
	parameter int DEPTH = pil_pkg::PIL_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pil_pkg::pil_req_t request,
	output logic              strobe,
	output pil_pkg::pil_res_t result
);
	import pil_pkg::*;

	pil_cmd_t  dp_cmd;
	pil_stat_t dp_stat;

	pil_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.stat    (dp_stat),
		.cmd     (dp_cmd),
		.busy    (busy)
	);

	pil_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (dp_cmd),
		.stat    (dp_stat),
		.strobe  (strobe),
		.result  (result)
	);

	// The controller leaves idle only on an accepted request
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

	// After a dump result that is not the last, strobe falls before the next result
	a_dump_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> !strobe)
		else $error("dump result not followed by a gap");

	// A dump keeps going until its last result
	a_dump_next: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> ##2 strobe)
		else $error("dump stopped before its last result");

	// A refused write is reported straight from idle
	a_full_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status == ST_FULL |-> !$past(busy) && result.last)
		else $error("full refusal outside idle");

endmodule
